### sv/msc_pkg.sv
package msc_pkg;

	// Residue width and derived sizes
	localparam int RES_W      = 31;
	localparam int SLOT_DEPTH = 11;
	localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
	localparam int YW         = RES_W + 1;
	localparam int IMM_W      = 4;
	localparam int STEP_W     = $clog2(YW / 2 + 1);
	localparam int PC_W       = 5;

	localparam logic [STEP_W-1:0] STEPS_FULL = STEP_W'(YW / 2);
	localparam logic [STEP_W-1:0] STEPS_IMM  = STEP_W'(IMM_W / 2);

	// Reciprocal of three for an exact floor(p / 3) on a 31-bit p
	localparam int RECIP_SH = RES_W + 2;
	localparam int RECIP_W  = RES_W + 1;
	localparam logic [RECIP_W-1:0] RECIP3 =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);
	localparam int PROD_W   = RES_W + RECIP_W;

	typedef logic [RES_W-1:0]   res_t;
	typedef logic [SLOT_AW-1:0] slot_t;
	typedef logic [IMM_W-1:0]   imm_t;
	typedef logic [PC_W-1:0]    pc_t;

	typedef struct packed {
		logic kind;
		res_t value;
	} item_t;

	typedef struct packed {
		res_t coef_three;
		res_t coef_four;
		res_t coef_five;
		res_t coef_six;
	} result_t;

	typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB} op_t;
	typedef enum logic [1:0] {XS_REG, XS_ONE, XS_INV} xsel_t;
	typedef enum logic [1:0] {YS_REG, YS_IMM, YS_VALUE, YS_SA} ysel_t;
	typedef enum logic [2:0] {D_RAM, D_A, D_C3, D_C4, D_C5, D_C6} dst_t;

	typedef struct packed {
		op_t   op;
		xsel_t xsel;
		slot_t xa;
		ysel_t ysel;
		slot_t ya;
		imm_t  imm;
		dst_t  dst;
		slot_t da;
		logic  last;
	} instr_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [STEP_W-1:0] steps;
	} alu_ctrl_t;

	// Scratch slots
	localparam slot_t S_A  = SLOT_AW'(0);
	localparam slot_t S_B  = SLOT_AW'(1);
	localparam slot_t S_A2 = SLOT_AW'(2);
	localparam slot_t S_A3 = SLOT_AW'(3);
	localparam slot_t S_A4 = SLOT_AW'(4);
	localparam slot_t S_A5 = SLOT_AW'(5);
	localparam slot_t S_A6 = SLOT_AW'(6);
	localparam slot_t S_B2 = SLOT_AW'(7);
	localparam slot_t S_B3 = SLOT_AW'(8);
	localparam slot_t S_T  = SLOT_AW'(9);
	localparam slot_t S_U  = SLOT_AW'(10);

	localparam imm_t K0 = IMM_W'(0);
	localparam imm_t K3 = IMM_W'(3);
	localparam imm_t K5 = IMM_W'(5);
	localparam imm_t K6 = IMM_W'(6);

	localparam pc_t PC_LOAD    = PC_W'(0);
	localparam pc_t PC_COMPUTE = PC_W'(1);

	// (a + b) mod p, a below p, b not above p
	function automatic res_t madd(input res_t a, input res_t b, input res_t p);
		logic [RES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, p}) begin
			s = s - {1'b0, p};
		end
		return s[RES_W-1:0];
	endfunction

	// (a - b) mod p, both below p
	function automatic res_t msub(input res_t a, input res_t b, input res_t p);
		res_t d;
		d = a - b;
		if (a < b) begin
			d = d + p;
		end
		return d;
	endfunction

	function automatic instr_t mk(input op_t op, input xsel_t xs, input slot_t xa,
			input ysel_t ys, input slot_t ya, input imm_t imm, input dst_t dst,
			input slot_t da, input logic last);
		instr_t i;
		i.op   = op;
		i.xsel = xs;
		i.xa   = xa;
		i.ysel = ys;
		i.ya   = ya;
		i.imm  = imm;
		i.dst  = dst;
		i.da   = da;
		i.last = last;
		return i;
	endfunction

	function automatic instr_t mrr(input slot_t x, input slot_t y, input slot_t d);
		return mk(OP_MUL, XS_REG, x, YS_REG, y, K0, D_RAM, d, 1'b0);
	endfunction

	function automatic instr_t mrk(input slot_t x, input imm_t k, input slot_t d);
		return mk(OP_MUL, XS_REG, x, YS_IMM, S_A, k, D_RAM, d, 1'b0);
	endfunction

	function automatic instr_t arr(input op_t op, input slot_t x, input slot_t y,
			input dst_t dst, input logic last);
		return mk(op, XS_REG, x, YS_REG, y, K0, dst, S_T, last);
	endfunction

	// Sequencer program: load at PC_LOAD, compute from PC_COMPUTE
	function automatic instr_t msc_prog(input pc_t pc);
		instr_t i;
		case (pc)
			PC_W'(0):  i = mk(OP_MUL, XS_INV, S_A, YS_VALUE, S_A, K0, D_A, S_A, 1'b1);
			PC_W'(1):  i = mk(OP_MUL, XS_ONE, S_A, YS_SA, S_A, K0, D_RAM, S_A, 1'b0);
			PC_W'(2):  i = mk(OP_MUL, XS_INV, S_A, YS_VALUE, S_A, K0, D_RAM, S_B, 1'b0);
			PC_W'(3):  i = mrr(S_A, S_A, S_A2);
			PC_W'(4):  i = mrr(S_A2, S_A, S_A3);
			PC_W'(5):  i = mrr(S_A2, S_A2, S_A4);
			PC_W'(6):  i = mrr(S_A4, S_A, S_A5);
			PC_W'(7):  i = mrr(S_A3, S_A3, S_A6);
			PC_W'(8):  i = mrr(S_B, S_B, S_B2);
			PC_W'(9):  i = mrr(S_B2, S_B, S_B3);
			PC_W'(10): i = mrr(S_B, S_A, S_T);
			PC_W'(11): i = mrk(S_T, K6, S_T);
			PC_W'(12): i = mrk(S_A3, K5, S_U);
			PC_W'(13): i = arr(OP_SUB, S_T, S_U, D_C3, 1'b0);
			PC_W'(14): i = mrk(S_B2, K3, S_T);
			PC_W'(15): i = mrr(S_B, S_A2, S_U);
			PC_W'(16): i = mrk(S_U, K3, S_U);
			PC_W'(17): i = arr(OP_SUB, S_T, S_U, D_C4, 1'b0);
			PC_W'(18): i = mrk(S_A5, K3, S_T);
			PC_W'(19): i = mrr(S_B, S_A3, S_U);
			PC_W'(20): i = mrk(S_U, K6, S_U);
			PC_W'(21): i = arr(OP_SUB, S_T, S_U, D_RAM, 1'b0);
			PC_W'(22): i = mrr(S_B2, S_A, S_U);
			PC_W'(23): i = mrk(S_U, K3, S_U);
			PC_W'(24): i = arr(OP_ADD, S_T, S_U, D_C5, 1'b0);
			PC_W'(25): i = mrr(S_B, S_A4, S_T);
			PC_W'(26): i = mrk(S_T, K3, S_T);
			PC_W'(27): i = arr(OP_SUB, S_T, S_A6, D_RAM, 1'b0);
			PC_W'(28): i = mrr(S_B2, S_A2, S_U);
			PC_W'(29): i = mrk(S_U, K3, S_U);
			PC_W'(30): i = arr(OP_SUB, S_T, S_U, D_RAM, 1'b0);
			PC_W'(31): i = arr(OP_ADD, S_T, S_B3, D_C6, 1'b1);
			default:   i = arr(OP_ADD, S_T, S_B3, D_C6, 1'b1);
		endcase
		return i;
	endfunction

endpackage

### sv/msc_ram.sv
module msc_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### sv/msc_alu.sv
module msc_alu import msc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  alu_ctrl_t       ctrl,
	input  res_t            x,
	input  logic [YW-1:0]   y,
	input  res_t            p,
	output logic            done,
	output res_t            result
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	res_t              r_q;
	res_t              x_q;
	logic [YW-1:0]     y_q;

	res_t r1, r2, r3, r4, arith;

	// Two bits of the multiplier per cycle, most significant first
	always_comb begin
		r1 = madd(r_q, r_q, p);
		r2 = y_q[YW-1] ? madd(r1, x_q, p) : r1;
		r3 = madd(r2, r2, p);
		r4 = y_q[YW-2] ? madd(r3, x_q, p) : r3;
	end

	always_comb begin
		case (ctrl.op)
			OP_ADD:  arith = madd(x, y[RES_W-1:0], p);
			OP_SUB:  arith = msub(x, y[RES_W-1:0], p);
			default: arith = x;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				if (ctrl.op == OP_MUL) begin
					r_q    <= '0;
					x_q    <= x;
					y_q    <= y;
					cnt_q  <= ctrl.steps - STEP_W'(1);
					busy_q <= 1'b1;
				end else begin
					r_q    <= arith;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				r_q   <= r4;
				y_q   <= y_q << 2;
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = r_q;

endmodule

### sv/modular_sextic_coefficients.sv
// Sextic coefficient unit over the integers modulo a prime p (p > 3) held in the
// configuration register (reset value 5). A load transfer (kind 0) stores
// a = value / 3 mod p and gives no result; a compute transfer (kind 1) takes
// b = value / 3 mod p and returns one result of four residues in [0, p):
// 6ba - 5a^3, 3b^2 - 3ba^2, 3a^5 - 6ba^3 + 3b^2a and 3ba^4 - a^6 - 3b^2a^2 + b^3.
// A modulus of zero stores zero on a load and answers zeros on a compute, with
// the result offered on the next cycle.
// All arithmetic runs on one shared modular unit under a 32-step program, after
// reciprocal and inverse states derive the inverse of three from p: a product runs
// two multiplier bits per cycle through a double-and-add reducer and a product by
// a small constant only the constant's bits, each with fetch, operand set-up and
// write-back states around it; an add or subtract passes through those states alone.
// The block takes no item while a load or compute runs and accepts configuration
// only when idle. A result waits in its output register until transferred.
module modular_sextic_coefficients import msc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  res_t    cfg_data,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RECIP, ST_INV, ST_FETCH, ST_OPND, ST_WAIT, ST_OUT
	} state_t;

	state_t             state_q;
	res_t               modulus_q;
	res_t               sa_q;
	logic               kind_q;
	res_t               value_q;
	logic [PROD_W-1:0]  prod_q;
	res_t               i3_q;
	pc_t                pc_q;
	result_t            res_q;

	instr_t             instr;
	alu_ctrl_t          alu_ctrl;
	res_t               alu_x;
	logic [YW-1:0]      alu_y;
	logic               alu_done;
	res_t               alu_result;
	res_t               rd_x, rd_y;
	logic               ram_we;

	logic [RES_W-2:0]   quot;
	res_t               quot3;
	res_t               rem;
	res_t               inv3;

	assign instr = msc_prog(pc_q);

	// Configuration takes precedence over a new item in the idle state
	assign cfg_ready  = (state_q == ST_IDLE);
	assign item_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign res_valid  = (state_q == ST_OUT);
	assign res        = res_q;

	// Inverse of three from floor(p / 3) and p mod 3
	always_comb begin
		quot  = prod_q[PROD_W-1:RECIP_SH];
		quot3 = {quot, 1'b0} + {1'b0, quot};
		rem   = modulus_q - quot3;
		case (rem[1:0])
			2'd1:    inv3 = {quot, 1'b1};
			2'd2:    inv3 = {1'b0, quot} + RES_W'(1);
			default: inv3 = {1'b0, quot};
		endcase
	end

	// Operand selection for the shared unit
	always_comb begin
		case (instr.xsel)
			XS_ONE:  alu_x = RES_W'(1);
			XS_INV:  alu_x = i3_q;
			default: alu_x = rd_x;
		endcase
		case (instr.ysel)
			YS_IMM:   alu_y = {instr.imm, (YW - IMM_W)'(0)};
			YS_VALUE: alu_y = {1'b0, value_q};
			YS_SA:    alu_y = {1'b0, sa_q};
			default:  alu_y = {1'b0, rd_y};
		endcase
		alu_ctrl.start = (state_q == ST_OPND);
		alu_ctrl.op    = instr.op;
		alu_ctrl.steps = (instr.ysel == YS_IMM) ? STEPS_IMM : STEPS_FULL;
	end

	assign ram_we = (state_q == ST_WAIT) && alu_done && (instr.dst == D_RAM);

	msc_ram #(
		.WIDTH(RES_W),
		.DEPTH(SLOT_DEPTH)
	) u_scratch (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (instr.da),
		.wdata  (alu_result),
		.raddr_a(instr.xa),
		.raddr_b(instr.ya),
		.rdata_a(rd_x),
		.rdata_b(rd_y)
	);

	msc_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (alu_ctrl),
		.x     (alu_x),
		.y     (alu_y),
		.p     (modulus_q),
		.done  (alu_done),
		.result(alu_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= RES_W'(5);
			sa_q      <= '0;
			pc_q      <= PC_LOAD;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						modulus_q <= cfg_data;
					end else if (item_valid) begin
						kind_q  <= item.kind;
						value_q <= item.value;
						if (modulus_q == '0) begin
							// Degenerate modulus: answer at once
							if (item.kind) begin
								res_q   <= '0;
								state_q <= ST_OUT;
							end else begin
								sa_q <= '0;
							end
						end else begin
							state_q <= ST_RECIP;
						end
					end
				end
				ST_RECIP: begin
					prod_q  <= PROD_W'(modulus_q) * PROD_W'(RECIP3);
					state_q <= ST_INV;
				end
				ST_INV: begin
					i3_q    <= inv3;
					pc_q    <= kind_q ? PC_COMPUTE : PC_LOAD;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_OPND;
				end
				ST_OPND: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (alu_done) begin
						case (instr.dst)
							D_A:     sa_q           <= alu_result;
							D_C3:    res_q.coef_three <= alu_result;
							D_C4:    res_q.coef_four  <= alu_result;
							D_C5:    res_q.coef_five  <= alu_result;
							D_C6:    res_q.coef_six   <= alu_result;
							default: ;
						endcase
						if (instr.last) begin
							state_q <= kind_q ? ST_OUT : ST_IDLE;
						end else begin
							pc_q    <= pc_q + PC_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				ST_OUT: begin
					// Hold the result until transferred
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The shared unit only reports completion while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == ST_WAIT)
		else $error("shared unit finished outside the wait state");

	// Every residue on offer lies below a nonzero modulus
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && modulus_q != '0 |->
			res.coef_three < modulus_q && res.coef_four < modulus_q &&
			res.coef_five < modulus_q && res.coef_six < modulus_q)
		else $error("result residue not reduced");

	// A finished load leaves a reduced a behind
	a_load_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT && alu_done && instr.last && !kind_q |=>
			sa_q < modulus_q)
		else $error("stored a not reduced");

endmodule
